// ----- rtl/tfn_pkg.sv -----
// Shared types and fixed widths for the triangle face normal pipeline.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none
package tfn_pkg;
    localparam int COORD_W = 16;
    localparam int FRAC_W  = 15;
    localparam int OUT_W   = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int T_SHIFT = 2 * FRAC_W + 2;
    localparam int RES_W   = SQ_W + T_SHIFT + 2;
    localparam int Y_W     = SQ_W + FRAC_W + 3;
    localparam int R_W     = FRAC_W + 1;
    // cross: 3 stages, prep: 3 stages, one per result bit, one output stage
    localparam int LATENCY = 3 + 3 + R_W + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
        logic                      last_in;
    } t_tri_word;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
        logic                    last_out;
    } t_norm_word;

    // control that rides along with each pipeline stage
    typedef struct packed {
        logic valid;
        logic last;
        logic degen;
    } t_ctl;
endpackage
`default_nettype wire

// ----- rtl/tfn_cross.sv -----
// Edge vectors, partial products and exact cross product (three stages).
// Depends on tfn_pkg.
`default_nettype none
module tfn_cross (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  tfn_pkg::t_tri_word        i_tri,
    output tfn_pkg::t_ctl             o_ctl,
    output logic [tfn_pkg::MAG_W-1:0] o_mag [3],
    output logic                      o_neg [3]
);
    import tfn_pkg::*;

    t_ctl r_ctl1, r_ctl2, r_ctl3;
    logic signed [DIFF_W-1:0] r_u [3];
    logic signed [DIFF_W-1:0] r_v [3];
    logic signed [PROD_W-1:0] r_p [6];
    logic        [MAG_W-1:0]  r_mag [3];
    logic                     r_neg [3];
    logic signed [CROSS_W-1:0] n_n [3];
    logic                      n_degen;

    // control pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else begin
            r_ctl1 <= '{valid: i_valid, last: i_tri.last_in, degen: 1'b0};
            r_ctl2 <= r_ctl1;
            r_ctl3 <= '{valid: r_ctl2.valid, last: r_ctl2.last, degen: n_degen};
        end
    end

    // cross components from the six products
    always_comb begin
        n_n[0] = CROSS_W'(r_p[0]) - CROSS_W'(r_p[1]);
        n_n[1] = CROSS_W'(r_p[2]) - CROSS_W'(r_p[3]);
        n_n[2] = CROSS_W'(r_p[4]) - CROSS_W'(r_p[5]);
        n_degen = (n_n[0] == '0) && (n_n[1] == '0) && (n_n[2] == '0);
    end

    // datapath: U = B - A, V = C - A; products; magnitude and sign
    always_ff @(posedge i_clk) begin
        r_u[0] <= DIFF_W'(i_tri.b_x) - DIFF_W'(i_tri.a_x);
        r_u[1] <= DIFF_W'(i_tri.b_y) - DIFF_W'(i_tri.a_y);
        r_u[2] <= DIFF_W'(i_tri.b_z) - DIFF_W'(i_tri.a_z);
        r_v[0] <= DIFF_W'(i_tri.c_x) - DIFF_W'(i_tri.a_x);
        r_v[1] <= DIFF_W'(i_tri.c_y) - DIFF_W'(i_tri.a_y);
        r_v[2] <= DIFF_W'(i_tri.c_z) - DIFF_W'(i_tri.a_z);
        r_p[0] <= PROD_W'(r_u[1]) * PROD_W'(r_v[2]);
        r_p[1] <= PROD_W'(r_u[2]) * PROD_W'(r_v[1]);
        r_p[2] <= PROD_W'(r_u[2]) * PROD_W'(r_v[0]);
        r_p[3] <= PROD_W'(r_u[0]) * PROD_W'(r_v[2]);
        r_p[4] <= PROD_W'(r_u[0]) * PROD_W'(r_v[1]);
        r_p[5] <= PROD_W'(r_u[1]) * PROD_W'(r_v[0]);
        for (int i = 0; i < 3; i++) begin
            r_neg[i] <= n_n[i][CROSS_W-1];
            r_mag[i] <= n_n[i][CROSS_W-1] ? MAG_W'(-n_n[i]) : MAG_W'(n_n[i]);
        end
    end

    assign o_ctl = r_ctl3;
    assign o_mag = r_mag;
    assign o_neg = r_neg;
endmodule
`default_nettype wire

// ----- rtl/tfn_prep.sv -----
// Squares, squared length and start values of the rounding recurrence.
// Depends on tfn_pkg.
`default_nettype none
module tfn_prep (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tfn_pkg::t_ctl                    i_ctl,
    input  logic        [tfn_pkg::MAG_W-1:0] i_mag [3],
    input  logic                             i_neg [3],
    output tfn_pkg::t_ctl                    o_ctl,
    output logic        [tfn_pkg::SQ_W-1:0]  o_s,
    output logic signed [tfn_pkg::Y_W-1:0]   o_y [3],
    output logic signed [tfn_pkg::RES_W-1:0] o_res [3],
    output logic                             o_neg [3]
);
    import tfn_pkg::*;

    t_ctl r_ctl4, r_ctl5, r_ctl6;
    logic [SQ_W-1:0] r_sq4 [3];
    logic [SQ_W-1:0] r_sq5 [3];
    logic [SQ_W-1:0] r_s5, r_s6;
    logic            r_neg4 [3];
    logic            r_neg5 [3];
    logic            r_neg6 [3];
    logic signed [Y_W-1:0]   r_y6;
    logic signed [RES_W-1:0] r_res6 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl4 <= '0;
            r_ctl5 <= '0;
            r_ctl6 <= '0;
        end else begin
            r_ctl4 <= i_ctl;
            r_ctl5 <= r_ctl4;
            r_ctl6 <= r_ctl5;
        end
    end

    // m^2 per lane, then S = sum, then R0 = m^2 * 2^(2F+2) - S and Y0 = -S
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sq4[i]  <= SQ_W'(i_mag[i]) * SQ_W'(i_mag[i]);
            r_neg4[i] <= i_neg[i];
            r_sq5[i]  <= r_sq4[i];
            r_neg5[i] <= r_neg4[i];
            r_neg6[i] <= r_neg5[i];
            r_res6[i] <= signed'(RES_W'({r_sq5[i], {T_SHIFT{1'b0}}}))
                       - signed'(RES_W'(r_s5));
        end
        r_s5 <= r_sq4[0] + r_sq4[1] + r_sq4[2];
        r_s6 <= r_s5;
        r_y6 <= -signed'(Y_W'(r_s5));
    end

    assign o_ctl = r_ctl6;
    assign o_s   = r_s6;
    assign o_res = r_res6;
    assign o_neg = r_neg6;
    assign o_y[0] = r_y6;
    assign o_y[1] = r_y6;
    assign o_y[2] = r_y6;
endmodule
`default_nettype wire

// ----- rtl/tfn_round_stage.sv -----
// One result bit of the exactly rounded quotient m * 2^F / sqrt(S), all lanes.
// Keeps R = m^2 * 2^(2F+2) - q^2 * S and Y = q * S with q = 2r - 1. Uses tfn_pkg.
`default_nettype none
module tfn_round_stage #(
    parameter int BIT = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tfn_pkg::t_ctl                    i_ctl,
    input  logic        [tfn_pkg::SQ_W-1:0]  i_s,
    input  logic signed [tfn_pkg::Y_W-1:0]   i_y [3],
    input  logic signed [tfn_pkg::RES_W-1:0] i_res [3],
    input  logic        [tfn_pkg::R_W-1:0]   i_r [3],
    input  logic                             i_neg [3],
    output tfn_pkg::t_ctl                    o_ctl,
    output logic        [tfn_pkg::SQ_W-1:0]  o_s,
    output logic signed [tfn_pkg::Y_W-1:0]   o_y [3],
    output logic signed [tfn_pkg::RES_W-1:0] o_res [3],
    output logic        [tfn_pkg::R_W-1:0]   o_r [3],
    output logic                             o_neg [3]
);
    import tfn_pkg::*;

    t_ctl r_ctl;
    logic [SQ_W-1:0]         r_s;
    logic signed [Y_W-1:0]   r_y [3];
    logic signed [RES_W-1:0] r_res [3];
    logic [R_W-1:0]          r_r [3];
    logic                    r_neg [3];
    logic signed [RES_W-1:0] n_cand [3];
    logic signed [RES_W-1:0] s_res;
    logic signed [Y_W-1:0]   s_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // trial: raising r by 2^BIT raises q by 2^(BIT+1)
    always_comb begin
        s_res = signed'(RES_W'(i_s));
        s_y   = signed'(Y_W'(i_s));
        for (int i = 0; i < 3; i++) begin
            n_cand[i] = i_res[i] - (RES_W'(i_y[i]) <<< (BIT + 2))
                      - (s_res <<< (2 * BIT + 2));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= i_s;
        for (int i = 0; i < 3; i++) begin
            r_neg[i] <= i_neg[i];
            if (!n_cand[i][RES_W-1]) begin
                r_res[i] <= n_cand[i];
                r_y[i]   <= i_y[i] + (s_y <<< (BIT + 1));
                r_r[i]   <= i_r[i] | (R_W'(1) << BIT);
            end else begin
                r_res[i] <= i_res[i];
                r_y[i]   <= i_y[i];
                r_r[i]   <= i_r[i];
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_y   = r_y;
    assign o_res = r_res;
    assign o_r   = r_r;
    assign o_neg = r_neg;
endmodule
`default_nettype wire

// ----- rtl/triangle_face_normal.sv -----
// Top level of the triangle face normal pipeline.
// Depends on tfn_pkg, tfn_cross, tfn_prep and tfn_round_stage.
//
//  channel  | handshake        | word
//  ---------+------------------+------------------------------------
//  triangle | start / busy     | i_tri  (tfn_pkg::t_tri_word)
//  normal   | o_valid (strobe) | o_norm (tfn_pkg::t_norm_word)
//
// One triangle per cycle while busy is low; between a taken triangle and its
// normal lie 3 stages of edges and cross product, 3 of squares and start values,
// 16 of the bit-per-stage rounding recurrence and 1 output register.
// busy is high only while i_rst_n is low; reset empties the pipeline.
// The receiver cannot stall, so nothing ever holds inside the pipeline.
`default_nettype none
module triangle_face_normal (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  tfn_pkg::t_tri_word  i_tri,
    output logic                o_valid,
    output tfn_pkg::t_norm_word o_norm
);
    import tfn_pkg::*;

    localparam logic [R_W-1:0] POS_MAX = R_W'(2 ** (OUT_W - 1) - 1);

    t_ctl                    w_ctl_c;
    logic [MAG_W-1:0]        w_mag [3];
    logic                    w_neg_c [3];
    t_ctl                    w_ctl [R_W+1];
    logic [SQ_W-1:0]         w_s [R_W+1];
    logic signed [Y_W-1:0]   w_y [R_W+1][3];
    logic signed [RES_W-1:0] w_res [R_W+1][3];
    logic [R_W-1:0]          w_r [R_W+1][3];
    logic                    w_neg [R_W+1][3];
    logic                    r_valid;
    t_norm_word              r_norm;
    logic [OUT_W-1:0]        n_comp [3];

    assign busy = !i_rst_n;

    tfn_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_tri   (i_tri),
        .o_ctl   (w_ctl_c),
        .o_mag   (w_mag),
        .o_neg   (w_neg_c)
    );

    tfn_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_c),
        .i_mag   (w_mag),
        .i_neg   (w_neg_c),
        .o_ctl   (w_ctl[0]),
        .o_s     (w_s[0]),
        .o_y     (w_y[0]),
        .o_res   (w_res[0]),
        .o_neg   (w_neg[0])
    );

    assign w_r[0][0] = '0;
    assign w_r[0][1] = '0;
    assign w_r[0][2] = '0;

    // result bits from MSB down
    for (genvar g = 0; g < R_W; g++) begin : g_round
        tfn_round_stage #(.BIT(R_W - 1 - g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_s     (w_s[g]),
            .i_y     (w_y[g]),
            .i_res   (w_res[g]),
            .i_r     (w_r[g]),
            .i_neg   (w_neg[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_s     (w_s[g+1]),
            .o_y     (w_y[g+1]),
            .o_res   (w_res[g+1]),
            .o_r     (w_r[g+1]),
            .o_neg   (w_neg[g+1])
        );
    end

    // sign, saturation of +1.0, degenerate zeroing
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_ctl[R_W].degen) begin
                n_comp[i] = '0;
            end else if (w_neg[R_W][i]) begin
                n_comp[i] = OUT_W'(~w_r[R_W][i] + R_W'(1));
            end else if (w_r[R_W][i] > POS_MAX) begin
                n_comp[i] = OUT_W'(POS_MAX);
            end else begin
                n_comp[i] = OUT_W'(w_r[R_W][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_ctl[R_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_norm.normal_x   <= n_comp[0];
        r_norm.normal_y   <= n_comp[1];
        r_norm.normal_z   <= n_comp[2];
        r_norm.degenerate <= w_ctl[R_W].degen;
        r_norm.last_out   <= w_ctl[R_W].last;
    end

    assign o_valid = r_valid;
    assign o_norm  = r_norm;
endmodule
`default_nettype wire

// ----- rtl/tfn_checker.sv -----
// Port-level checks for triangle_face_normal, bound to the top level.
// Depends on tfn_pkg.
`default_nettype none
module tfn_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      start,
    input wire                      busy,
    input tfn_pkg::t_tri_word       i_tri,
    input wire                      o_valid,
    input tfn_pkg::t_norm_word      o_norm
);
    import tfn_pkg::*;

    // every taken triangle gives a word after the fixed latency
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(LATENCY) o_valid)
        else $error("triangle taken but no normal word");

    // no word without a triangle taken earlier
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("normal word without triangle");

    // marker travels with its triangle
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_norm.last_out == $past(i_tri.last_in, LATENCY)))
        else $error("last marker mismatch");

    // degenerate gives zero normal; otherwise a unit normal is never all zero
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_norm.degenerate ==
            ((o_norm.normal_x == '0) && (o_norm.normal_y == '0)
             && (o_norm.normal_z == '0))))
        else $error("degenerate flag and normal disagree");
endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_tri   (i_tri),
    .o_valid (o_valid),
    .o_norm  (o_norm)
);
`default_nettype wire

// ----- verif/triangle_face_normal_tb.sv -----
// Self-checking testbench for triangle_face_normal: directed and random triangles,
// predicted exact unit normals compared word by word. Depends on tfn_pkg and the RTL.
`timescale 1ns / 1ps
module triangle_face_normal_tb;
    import tfn_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_tri_word  i_tri;
    logic       o_valid;
    t_norm_word o_norm;

    t_tri_word  tri_pending[$];
    t_norm_word normal_expected[$];
    int         idle_pct;
    int         errors;
    bit         word_taken;

    triangle_face_normal i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_tri   (i_tri),
        .o_valid (o_valid),
        .o_norm  (o_norm)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // largest r in [0, 2^FRAC_W] with (2r-1)^2 * s <= 4 * m^2 * 2^(2*FRAC_W)
    function automatic logic [31:0] round_unit(logic [159:0] m, logic [159:0] s);
        logic [159:0] target;
        logic [159:0] d;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  mid;
        target = (m * m) << (2 * FRAC_W + 2);
        lo = 0;
        hi = 32'd1 << FRAC_W;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            d = 2 * mid - 1;
            if (d * d * s <= target) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic t_norm_word face_normal(t_tri_word t);
        longint       ux, uy, uz, vx, vy, vz;
        longint       n[3];
        logic [159:0] m[3];
        logic [159:0] s;
        logic [31:0]  r;
        t_norm_word   res;
        logic [OUT_W-1:0] comp[3];
        ux = longint'($signed(t.b_x)) - longint'($signed(t.a_x));
        uy = longint'($signed(t.b_y)) - longint'($signed(t.a_y));
        uz = longint'($signed(t.b_z)) - longint'($signed(t.a_z));
        vx = longint'($signed(t.c_x)) - longint'($signed(t.a_x));
        vy = longint'($signed(t.c_y)) - longint'($signed(t.a_y));
        vz = longint'($signed(t.c_z)) - longint'($signed(t.a_z));
        n[0] = uy * vz - uz * vy;
        n[1] = uz * vx - ux * vz;
        n[2] = ux * vy - uy * vx;
        for (int i = 0; i < 3; i++) m[i] = (n[i] < 0) ? 160'(-n[i]) : 160'(n[i]);
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        res = '0;
        res.last_out = t.last_in;
        if (s == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            r = round_unit(m[i], s);
            if (n[i] < 0) begin
                if (r > 32768) r = 32768;
                comp[i] = OUT_W'(-r);
            end else begin
                if (r > 32767) r = 32767;
                comp[i] = OUT_W'(r);
            end
        end
        res.normal_x = comp[0];
        res.normal_y = comp[1];
        res.normal_z = comp[2];
        return res;
    endfunction

    function automatic t_tri_word make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                           int cx, int cy, int cz, bit last);
        t_tri_word t;
        t.a_x = COORD_W'(ax); t.a_y = COORD_W'(ay); t.a_z = COORD_W'(az);
        t.b_x = COORD_W'(bx); t.b_y = COORD_W'(by); t.b_z = COORD_W'(bz);
        t.c_x = COORD_W'(cx); t.c_y = COORD_W'(cy); t.c_z = COORD_W'(cz);
        t.last_in = last;
        return t;
    endfunction

    function automatic logic [15:0] near(logic [15:0] base, int spread);
        return base + 16'($urandom_range(2 * spread) - spread);
    endfunction

    function automatic t_tri_word random_tri();
        t_tri_word t;
        int        k;
        t = t_tri_word'({$urandom, $urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(9)) inside
            [0:2]: ;                                // full range
            [3:5]: begin                            // small, nearby vertices
                t.b_x = near(t.a_x, 40); t.b_y = near(t.a_y, 40); t.b_z = near(t.a_z, 40);
                t.c_x = near(t.a_x, 40); t.c_y = near(t.a_y, 40); t.c_z = near(t.a_z, 40);
            end
            6: begin                                // collinear
                t.a_x = near('0, 500); t.a_y = near('0, 500); t.a_z = near('0, 500);
                t.b_x = near(t.a_x, 50); t.b_y = near(t.a_y, 50); t.b_z = near(t.a_z, 50);
                k = $urandom_range(6) - 3;
                t.c_x = COORD_W'(t.a_x + k * (t.b_x - t.a_x));
                t.c_y = COORD_W'(t.a_y + k * (t.b_y - t.a_y));
                t.c_z = COORD_W'(t.a_z + k * (t.b_z - t.a_z));
            end
            7: t.c_x = t.b_x;                       // one shared coordinate
            8: begin                                // axis-aligned plane
                t.b_z = t.a_z; t.c_z = t.a_z;
            end
            default: begin                          // a_x, b_y and c_z at extremes
                t = t_tri_word'({$urandom, $urandom, $urandom, $urandom, $urandom});
                t.a_x = ($urandom & 1) ? 16'h8000 : 16'h7fff;
                t.b_y = ($urandom & 1) ? 16'h8000 : 16'h7fff;
                t.c_z = ($urandom & 1) ? 16'h8000 : 16'h7fff;
            end
        endcase
        return t;
    endfunction

    // driver: drop the word taken at the last edge, then offer the next one
    always @(negedge i_clk) begin
        if (word_taken) void'(tri_pending.pop_front());
        if (i_rst_n && tri_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            i_tri <= tri_pending[0];
        end else begin
            start <= 1'b0;
            i_tri <= t_tri_word'({$urandom, $urandom, $urandom, $urandom, $urandom});
        end
    end

    // acceptance and result checking
    always @(posedge i_clk) begin
        t_norm_word exp_w;
        word_taken = i_rst_n && start && !busy;
        if (word_taken) normal_expected.push_back(face_normal(i_tri));
        if (i_rst_n && o_valid) begin
            if (normal_expected.size() == 0) begin
                $error("unexpected normal word %h", o_norm);
                errors++;
            end else begin
                exp_w = normal_expected.pop_front();
                if (o_norm.normal_x !== exp_w.normal_x) begin
                    $error("normal_x exp %0d got %0d", exp_w.normal_x, o_norm.normal_x);
                    errors++;
                end
                if (o_norm.normal_y !== exp_w.normal_y) begin
                    $error("normal_y exp %0d got %0d", exp_w.normal_y, o_norm.normal_y);
                    errors++;
                end
                if (o_norm.normal_z !== exp_w.normal_z) begin
                    $error("normal_z exp %0d got %0d", exp_w.normal_z, o_norm.normal_z);
                    errors++;
                end
                if (o_norm.degenerate !== exp_w.degenerate) begin
                    $error("degenerate exp %0b got %0b", exp_w.degenerate, o_norm.degenerate);
                    errors++;
                end
                if (o_norm.last_out !== exp_w.last_out) begin
                    $error("last_out exp %0b got %0b", exp_w.last_out, o_norm.last_out);
                    errors++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #5ms;
        $display("** triangle_face_normal: FAILED **");
        $finish;
    end

    task automatic drain();
        wait (tri_pending.size() == 0 && !word_taken);
        @(posedge i_clk);
        wait (normal_expected.size() == 0);
    endtask

    initial begin
        int phase_pct[4];
        phase_pct = '{0, 67, 0, 25};
        errors = 0;
        word_taken = 0;
        idle_pct = 0;
        start = 1'b0;
        i_tri = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: degenerate, unit axes, full-scale extremes, tiny triangles
        tri_pending.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        tri_pending.push_back(make_tri(5, 5, 5, 5, 5, 5, 9, 1, 2, 1));
        tri_pending.push_back(make_tri(0, 0, 0, 1, 2, 3, 2, 4, 6, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0, 1));
        tri_pending.push_back(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1, 0));
        tri_pending.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                       -32768, 32767, -32768, 0));
        tri_pending.push_back(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                                       32767, -32768, 32767, 1));
        tri_pending.push_back(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                                       32767, 32767, -32768, 0));
        tri_pending.push_back(make_tri(32767, -32768, 0, -32768, 32767, 0,
                                       0, 0, 32767, 1));
        tri_pending.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                       -32768, -32768, -32768, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 1, 1, 0, 1, 0, 1, 0));
        tri_pending.push_back(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 0, 1));
        tri_pending.push_back(make_tri(10, 20, 30, 11, 22, 31, 13, 19, 35, 0));
        drain();

        // random phases at idle rates of 0, 67, 0 and 25 percent; drain after each one
        for (int p = 0; p < 4; p++) begin
            idle_pct = phase_pct[p];
            for (int i = 0; i < 160; i++) tri_pending.push_back(random_tri());
            drain();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && normal_expected.size() == 0)
            $display("** triangle_face_normal: PASSED **");
        else
            $display("** triangle_face_normal: FAILED **");
        $finish;
    end
endmodule
